### rtl/assert_macros.svh
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge outside reset
`define LBPF_ASSERT_TRUE(lbl, clk_s, rstn_s, expr) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (expr)) \
        else $error("lbpf assertion failed");

// same-cycle implication
`define LBPF_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("lbpf assertion failed");

// next-cycle implication
`define LBPF_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("lbpf assertion failed");

`endif

### rtl/lbpf_pkg.sv
`default_nettype none

package lbpf_pkg;

    localparam int LINE_CAPACITY_DEF = 1920;

    localparam int HEIGHT_W   = 12;
    localparam int WIDTH_W    = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int WORD_W     = 24;   // three 8-bit row slots per column

    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 12'd1080;
    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd1920;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;

    localparam logic [7:0] COEF_R = 8'd77;
    localparam logic [7:0] COEF_G = 8'd150;
    localparam logic [7:0] COEF_B = 8'd29;

    typedef logic [1:0] slot_t;

    typedef struct packed {
        logic [23:0] pixel_rgb;
        logic [2:0]  byte_keep;
        logic [2:0]  byte_strobe;
    } pix_t;

    typedef struct packed {
        logic [23:0] lbp_rgb;
        logic [2:0]  keep_out;
        logic [2:0]  strobe_out;
        logic        frame_start;
        logic        line_end;
    } res_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

    function automatic logic [7:0] to_gray(input logic [23:0] rgb);
        logic [15:0] acc;
        acc = 16'(rgb[23:16]) * 16'(COEF_R)
            + 16'(rgb[15:8])  * 16'(COEF_G)
            + 16'(rgb[7:0])   * 16'(COEF_B);
        return acc[15:8];
    endfunction

    function automatic logic [7:0] byte_of(input logic [WORD_W-1:0] word, input slot_t s);
        logic [7:0] b;
        case (s)
            2'd0:    b = word[7:0];
            2'd1:    b = word[15:8];
            2'd2:    b = word[23:16];
            default: b = word[7:0];
        endcase
        return b;
    endfunction

    function automatic logic [WORD_W-1:0] with_byte(input logic [WORD_W-1:0] word,
                                                     input slot_t s,
                                                     input logic [7:0] b);
        logic [WORD_W-1:0] w;
        w = word;
        case (s)
            2'd0:    w[7:0]   = b;
            2'd1:    w[15:8]  = b;
            2'd2:    w[23:16] = b;
            default: w[7:0]   = b;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### rtl/lbpf_linebuf.sv
`default_nettype none

// Column-indexed line store: one word per column, one gray byte per row slot.
module lbpf_linebuf #(
    parameter int DEPTH = lbpf_pkg::LINE_CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                        clk,
    input  wire lbpf_pkg::mem_ctl_t          ctl,
    input  wire logic [AW-1:0]               rd_addr,
    input  wire logic [AW-1:0]               wr_addr,
    input  wire logic [lbpf_pkg::WORD_W-1:0] wr_word,
    output logic      [lbpf_pkg::WORD_W-1:0] rd_word
);
    import lbpf_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_word_reg;

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_word;
        end
        if (ctl.rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    assign rd_word = rd_word_reg;

endmodule

`default_nettype wire

### rtl/lbp_3x3_rgb_stream_filter.sv
`default_nettype none

// Channel | Dir | Handshake             | Payload
// pix     | in  | pix_valid/pix_ready   | pix_data  (lbpf_pkg::pix_t)
// res     | out | res_valid/res_ready   | res_data  (lbpf_pkg::res_t)
// cfg     | in  | cfg_valid/cfg_ready   | cfg_index, cfg_data (0: height, 1: width)
//
// One pixel per clock sustained while the output is not stalled; a result passes
// the stage-1 register and then the output register before its output transfer.
// The rate is set by the single line-store read-modify-write per pixel
// (read at accept, write back when stage 1 leaves).
// Reset clears counters and pipeline valids; the line store is not cleared,
// so the block takes pixels from the first cycle after reset.
// Output stalls back up through the stage-1 register to pix_ready.
module lbp_3x3_rgb_stream_filter #(
    parameter int LINE_CAPACITY = lbpf_pkg::LINE_CAPACITY_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            pix_valid,
    output logic                                 pix_ready,
    input  wire lbpf_pkg::pix_t                  pix_data,
    output logic                                 res_valid,
    input  wire logic                            res_ready,
    output lbpf_pkg::res_t                       res_data,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [lbpf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lbpf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lbpf_pkg::*;

    localparam int XW    = $clog2(LINE_CAPACITY);
    localparam int CMP_W = ((XW > WIDTH_W) ? XW : WIDTH_W) + 1;
    localparam int ROW_C = HEIGHT_W + 1;

    // configuration
    logic [HEIGHT_W-1:0] frame_height_reg;
    logic [WIDTH_W-1:0]  frame_width_reg;

    // raster position of the next pixel
    logic [XW-1:0]       col_reg, col_next;
    logic [HEIGHT_W-1:0] row_reg, row_next;
    slot_t               slot_reg, slot_next;

    // stage 1: line-store word arrives here
    logic              s1_valid_reg;
    logic [XW-1:0]     s1_col_reg;
    slot_t             s1_slot_reg;
    logic [7:0]        s1_gray_reg;
    logic              s1_inner_reg;
    logic [2:0]        s1_keep_reg;
    logic [2:0]        s1_strobe_reg;
    logic              s1_fs_reg;
    logic              s1_le_reg;
    logic              s1_fwd_reg;
    logic [WORD_W-1:0] s1_fwd_word_reg;

    // previous two columns of the window (top, mid, current row)
    logic [7:0] w1_top_reg, w1_mid_reg, w1_cur_reg;
    logic [7:0] w2_top_reg, w2_mid_reg, w2_cur_reg;

    logic res_valid_reg;
    res_t res_data_reg;

    logic              pix_fire, s1_adv;
    logic [CMP_W-1:0]  fw_ext, cap_ext, w_act;
    logic [ROW_C-1:0]  h_act;
    logic              col_last, row_last;
    logic              inner, frame_first;
    logic [7:0]        gray;
    mem_ctl_t          mem_ctl;
    logic [WORD_W-1:0] rd_word, word, merged;
    slot_t             top_slot, mid_slot;
    logic [7:0]        col_top, col_mid, ctr;
    logic [7:0]        code;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_height_reg <= HEIGHT_RST;
            frame_width_reg  <= WIDTH_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[HEIGHT_W-1:0];
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[WIDTH_W-1:0];
                default:          ;
            endcase
        end
    end

    // handshake: stage 1 moves when the output register is free or draining
    assign s1_adv    = s1_valid_reg && (!res_valid_reg || res_ready);
    assign pix_ready = !s1_valid_reg || s1_adv;
    assign pix_fire  = pix_valid && pix_ready;

    // width clamps to capacity, zero means one
    assign fw_ext  = CMP_W'(frame_width_reg);
    assign cap_ext = CMP_W'(LINE_CAPACITY);
    assign w_act   = (fw_ext > cap_ext) ? cap_ext :
                     ((fw_ext == '0) ? CMP_W'(1) : fw_ext);
    assign h_act   = (frame_height_reg == '0) ? ROW_C'(1) : ROW_C'(frame_height_reg);

    assign col_last    = (CMP_W'(col_reg) + CMP_W'(1)) >= w_act;
    assign row_last    = (ROW_C'(row_reg) + ROW_C'(1)) >= h_act;
    assign inner       = (col_reg >= XW'(2)) && (row_reg >= HEIGHT_W'(2));
    assign frame_first = (col_reg == '0) && (row_reg == '0);
    assign gray        = to_gray(pix_data.pixel_rgb);

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        slot_next = slot_reg;
        if (pix_fire)
        begin
            if (col_last)
            begin
                col_next = '0;
                if (row_last)
                begin
                    row_next  = '0;
                    slot_next = '0;
                end
                else
                begin
                    row_next  = row_reg + HEIGHT_W'(1);
                    slot_next = (slot_reg == 2'd2) ? 2'd0 : slot_reg + 2'd1;
                end
            end
            else
            begin
                col_next = col_reg + XW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
        end
    end

    // line store: read at accept, write back the merged word when stage 1 leaves
    assign mem_ctl.rd_en = pix_fire;
    assign mem_ctl.wr_en = s1_adv;

    lbpf_linebuf #(
        .DEPTH (LINE_CAPACITY),
        .AW    (XW)
    ) u_linebuf (
        .clk     (clk),
        .ctl     (mem_ctl),
        .rd_addr (col_reg),
        .wr_addr (s1_col_reg),
        .wr_word (merged),
        .rd_word (rd_word)
    );

    // forward the word being written if the next pixel reads the same column
    // (width of one, or a width change)
    assign word     = s1_fwd_reg ? s1_fwd_word_reg : rd_word;
    assign merged   = with_byte(word, s1_slot_reg, s1_gray_reg);
    assign top_slot = (s1_slot_reg == 2'd2) ? 2'd0 : s1_slot_reg + 2'd1;
    assign mid_slot = (s1_slot_reg == 2'd0) ? 2'd2 : s1_slot_reg - 2'd1;
    assign col_top  = byte_of(word, top_slot);
    assign col_mid  = byte_of(word, mid_slot);
    assign ctr      = w1_mid_reg;

    // bit 7 top-left, clockwise to bit 0 left
    always_comb
    begin
        code = {w2_top_reg  >= ctr,
                w1_top_reg  >= ctr,
                col_top     >= ctr,
                col_mid     >= ctr,
                s1_gray_reg >= ctr,
                w1_cur_reg  >= ctr,
                w2_cur_reg  >= ctr,
                w2_mid_reg  >= ctr};
        if (!s1_inner_reg)
        begin
            code = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_fwd_reg   <= 1'b0;
        end
        else
        begin
            if (pix_fire)
            begin
                s1_valid_reg <= 1'b1;
                s1_fwd_reg   <= s1_adv && (s1_col_reg == col_reg);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_fire)
        begin
            s1_col_reg      <= col_reg;
            s1_slot_reg     <= slot_reg;
            s1_gray_reg     <= gray;
            s1_inner_reg    <= inner;
            s1_keep_reg     <= pix_data.byte_keep;
            s1_strobe_reg   <= pix_data.byte_strobe;
            s1_fs_reg       <= frame_first;
            s1_le_reg       <= col_last;
            s1_fwd_word_reg <= merged;
        end
        if (s1_adv)
        begin
            w2_top_reg <= w1_top_reg;
            w2_mid_reg <= w1_mid_reg;
            w2_cur_reg <= w1_cur_reg;
            w1_top_reg <= col_top;
            w1_mid_reg <= col_mid;
            w1_cur_reg <= s1_gray_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            res_data_reg.lbp_rgb     <= {code, code, code};
            res_data_reg.keep_out    <= s1_keep_reg;
            res_data_reg.strobe_out  <= s1_strobe_reg;
            res_data_reg.frame_start <= s1_fs_reg;
            res_data_reg.line_end    <= s1_le_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

`default_nettype wire

### rtl/lbpf_checker.sv
`default_nettype none
`include "assert_macros.svh"

module lbpf_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           pix_valid,
    input wire logic           pix_ready,
    input wire logic           res_valid,
    input wire logic           res_ready,
    input wire lbpf_pkg::res_t res_data
);
    import lbpf_pkg::*;

    // pixels taken but not yet delivered
    logic [1:0] occ_reg, occ_next;
    logic       pix_xfer, res_xfer;
    logic       res_wait, bytes_match;

    assign pix_xfer    = pix_valid && pix_ready;
    assign res_xfer    = res_valid && res_ready;
    assign res_wait    = res_valid && !res_ready;
    assign bytes_match = (res_data.lbp_rgb[23:16] == res_data.lbp_rgb[15:8])
                         && (res_data.lbp_rgb[15:8] == res_data.lbp_rgb[7:0]);

    always_comb
    begin
        occ_next = occ_reg;
        if (pix_xfer && !res_xfer)
        begin
            occ_next = occ_reg + 2'd1;
        end
        else if (res_xfer && !pix_xfer)
        begin
            occ_next = occ_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    `LBPF_ASSERT_TRUE(a_occ_max, clk, rst_n, occ_reg <= 2'd2)
    `LBPF_ASSERT_IMP(a_no_phantom, clk, rst_n, occ_reg == 2'd0, !res_valid)
    `LBPF_ASSERT_NXT(a_res_hold, clk, rst_n, res_wait, res_valid && $stable(res_data))
    `LBPF_ASSERT_IMP(a_bytes_same, clk, rst_n, res_valid, bytes_match)
    `LBPF_ASSERT_IMP(a_first_border, clk, rst_n, res_valid && res_data.frame_start, res_data.lbp_rgb == 24'd0)

endmodule

bind lbp_3x3_rgb_stream_filter lbpf_checker u_lbpf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
);

`default_nettype wire
